// File: rtl/x86op_pkg.sv
package x86op_pkg;

	// operand form codes, sampled with the start byte
	localparam logic [1:0] FORM_MODRM  = 2'b00;
	localparam logic [1:0] FORM_IMM    = 2'b01;
	localparam logic [1:0] FORM_OFFSET = 2'b10;
	localparam logic [1:0] FORM_RSVD   = 2'b11;

	localparam logic [1:0] MOD_NODISP = 2'b00;
	localparam logic [1:0] MOD_DISP8  = 2'b01;
	localparam logic [1:0] MOD_DISP32 = 2'b10;
	localparam logic [1:0] MOD_REG    = 2'b11;

	localparam logic [2:0] RM_SIB    = 3'b100;
	localparam logic [2:0] RM_DISP32 = 3'b101;
	localparam logic [2:0] BASE_NONE = 3'b101;

	localparam logic [3:0] IMM_MAX    = 4'd8;
	localparam logic [2:0] DISP_LEN1  = 3'd1;
	localparam logic [2:0] DISP_LEN4  = 3'd4;

	typedef enum logic [4:0] {
		PH_IDLE  = 5'b00001,
		PH_MODRM = 5'b00010,
		PH_SIB   = 5'b00100,
		PH_DISP  = 5'b01000,
		PH_IMM   = 5'b10000
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_req;
		logic [1:0] form;
		logic [3:0] imm_bytes;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  mod_field;
		logic [2:0]  reg_field;
		logic [2:0]  rm_field;
		logic        sib_present;
		logic [1:0]  sib_scale;
		logic [2:0]  sib_index;
		logic [2:0]  sib_base;
		logic [2:0]  disp_size;
		logic [31:0] displacement;
		logic [63:0] immediate;
		logic [3:0]  bytes_used;
	} out_item_t;

	typedef struct packed {
		phase_t      phase;
		logic [1:0]  saved_form;
		logic [3:0]  imm_remaining;
		logic [2:0]  disp_remaining;
		logic [7:0]  modrm_byte;
		logic [7:0]  sib_byte;
		logic [31:0] disp_acc;
		logic [63:0] imm_acc;
		logic [3:0]  byte_count;
	} parse_state_t;

	function automatic logic has_sib(input logic [1:0] form, input logic [7:0] modrm);
		return (form == FORM_MODRM) && (modrm[7:6] != MOD_REG) && (modrm[2:0] == RM_SIB);
	endfunction

	function automatic logic [2:0] disp_len(input logic [1:0] form, input logic [7:0] modrm,
			input logic [7:0] sib);
		logic [2:0] len;
		len = 3'd0;
		if (form == FORM_OFFSET) begin
			len = DISP_LEN4;
		end else if (form == FORM_MODRM) begin
			case (modrm[7:6])
				MOD_DISP8:  len = DISP_LEN1;
				MOD_DISP32: len = DISP_LEN4;
				MOD_NODISP: begin
					if (modrm[2:0] == RM_DISP32)
						len = DISP_LEN4;
					else if (modrm[2:0] == RM_SIB && sib[2:0] == BASE_NONE)
						len = DISP_LEN4;
				end
				default: len = 3'd0;
			endcase
		end
		return len;
	endfunction

	function automatic logic [3:0] pre_disp_len(input logic [1:0] form, input logic [7:0] modrm);
		logic [3:0] len;
		len = 4'd0;
		if (form == FORM_MODRM)
			len = has_sib(form, modrm) ? 4'd2 : 4'd1;
		return len;
	endfunction

endpackage

// File: rtl/x86op_in_if.sv
interface x86op_in_if;
	import x86op_pkg::*;

	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/x86op_out_if.sv
interface x86op_out_if;
	import x86op_pkg::*;

	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/x86op_step.sv
module x86op_step (
	input  x86op_pkg::parse_state_t cur,
	input  x86op_pkg::in_item_t     item,
	output x86op_pkg::parse_state_t nxt,
	output logic                    emit,
	output x86op_pkg::out_item_t    result
);
	import x86op_pkg::*;

	parse_state_t eff;
	logic         empty_emit;
	logic [1:0]   form_eff;
	logic [3:0]   imm_eff;
	logic [1:0]   disp_idx;
	logic [2:0]   imm_idx;
	logic         sib_now;

	// start request resets the context before the byte is taken
	always_comb begin
		eff        = cur;
		empty_emit = 1'b0;
		form_eff   = (item.form == FORM_RSVD) ? FORM_IMM : item.form;
		imm_eff    = (item.imm_bytes > IMM_MAX) ? IMM_MAX : item.imm_bytes;
		if (item.start_req) begin
			eff.saved_form     = form_eff;
			eff.imm_remaining  = imm_eff;
			eff.disp_remaining = 3'd0;
			eff.modrm_byte     = 8'd0;
			eff.sib_byte       = 8'd0;
			eff.disp_acc       = 32'd0;
			eff.imm_acc        = 64'd0;
			eff.byte_count     = 4'd0;
			case (form_eff)
				FORM_MODRM: eff.phase = PH_MODRM;
				FORM_OFFSET: begin
					eff.imm_remaining  = 4'd0;
					eff.disp_remaining = DISP_LEN4;
					eff.phase          = PH_DISP;
				end
				default: begin
					eff.phase  = PH_IMM;
					empty_emit = (imm_eff == 4'd0);
				end
			endcase
		end
	end

	always_comb begin
		nxt      = eff;
		emit     = 1'b0;
		sib_now  = has_sib(eff.saved_form, item.data_byte);
		disp_idx = 2'(eff.byte_count - pre_disp_len(eff.saved_form, eff.modrm_byte));
		imm_idx  = 3'(eff.byte_count - pre_disp_len(eff.saved_form, eff.modrm_byte)
			- 4'(disp_len(eff.saved_form, eff.modrm_byte, eff.sib_byte)));
		if (empty_emit) begin
			emit      = 1'b1;
			nxt.phase = PH_IDLE;
		end else begin
			case (eff.phase)
				PH_MODRM: begin
					nxt.modrm_byte = item.data_byte;
					nxt.byte_count = eff.byte_count + 4'd1;
					if (sib_now) begin
						nxt.phase = PH_SIB;
					end else begin
						nxt.disp_remaining = disp_len(eff.saved_form, item.data_byte,
							eff.sib_byte);
						nxt.phase = PH_DISP;
					end
				end
				PH_SIB: begin
					nxt.sib_byte       = item.data_byte;
					nxt.byte_count     = eff.byte_count + 4'd1;
					nxt.disp_remaining = disp_len(eff.saved_form, eff.modrm_byte,
						item.data_byte);
					nxt.phase          = PH_DISP;
				end
				PH_DISP: begin
					nxt.disp_acc   = eff.disp_acc | (32'(item.data_byte) << {disp_idx, 3'b000});
					nxt.byte_count = eff.byte_count + 4'd1;
					if (eff.disp_remaining != 3'd0)
						nxt.disp_remaining = eff.disp_remaining - 3'd1;
				end
				PH_IMM: begin
					nxt.imm_acc    = eff.imm_acc | (64'(item.data_byte) << {imm_idx, 3'b000});
					nxt.byte_count = eff.byte_count + 4'd1;
					if (eff.imm_remaining != 4'd0)
						nxt.imm_remaining = eff.imm_remaining - 4'd1;
				end
				default: nxt.phase = PH_IDLE;
			endcase
			// zero-length displacement or immediate falls straight through
			if (nxt.phase == PH_DISP && nxt.disp_remaining == 3'd0)
				nxt.phase = PH_IMM;
			if (nxt.phase == PH_IMM && nxt.imm_remaining == 4'd0) begin
				emit      = 1'b1;
				nxt.phase = PH_IDLE;
			end
		end
	end

	logic f0;
	logic s;

	always_comb begin
		f0 = (nxt.saved_form == FORM_MODRM);
		s  = has_sib(nxt.saved_form, nxt.modrm_byte);
		result.mod_field    = f0 ? nxt.modrm_byte[7:6] : 2'd0;
		result.reg_field    = f0 ? nxt.modrm_byte[5:3] : 3'd0;
		result.rm_field     = f0 ? nxt.modrm_byte[2:0] : 3'd0;
		result.sib_present  = s;
		result.sib_scale    = s ? nxt.sib_byte[7:6] : 2'd0;
		result.sib_index    = s ? nxt.sib_byte[5:3] : 3'd0;
		result.sib_base     = s ? nxt.sib_byte[2:0] : 3'd0;
		result.disp_size    = disp_len(nxt.saved_form, nxt.modrm_byte, nxt.sib_byte);
		result.displacement = nxt.disp_acc;
		result.immediate    = nxt.imm_acc;
		result.bytes_used   = nxt.byte_count;
	end

endmodule

// File: rtl/x86op_core_regs.sv
module x86op_core_regs (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    load,
	input  x86op_pkg::parse_state_t nxt,
	output x86op_pkg::parse_state_t cur
);
	import x86op_pkg::*;

	parse_state_t st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase          <= PH_IDLE;
			st_q.saved_form     <= FORM_MODRM;
			st_q.imm_remaining  <= 4'd0;
			st_q.disp_remaining <= 3'd0;
			st_q.modrm_byte     <= 8'd0;
			st_q.sib_byte       <= 8'd0;
			st_q.disp_acc       <= 32'd0;
			st_q.imm_acc        <= 64'd0;
			st_q.byte_count     <= 4'd0;
		end else if (load) begin
			st_q <= nxt;
		end
	end

	assign cur = st_q;

	// idle context never holds outstanding byte counts
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.phase == PH_IDLE |-> st_q.imm_remaining == 4'd0 && st_q.disp_remaining == 3'd0)
		else $error("idle parser holds remaining byte count");

	a_sib_only_form0: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.phase == PH_SIB |-> st_q.saved_form == FORM_MODRM && st_q.byte_count == 4'd1)
		else $error("sib phase outside modrm form");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.byte_count <= 4'd14)
		else $error("byte count beyond longest operand tail");

endmodule

// File: rtl/x86_modrm_sib_operand_parser_core.sv
// x86 operand tail parser: ModRM, SIB, displacement and immediate
//
// byte_stream carries one instruction byte per request, following the opcode.
// start_req marks the first byte of an instruction and samples form and
// imm_bytes; a start in the middle of an instruction drops the partial one.
// operands carries one request per completed instruction with the decoded
// fields, zero-extended displacement and immediate, and the byte count.
//
// Throughput is one byte per cycle while no result is pending. The result is
// registered: it shows on operands the cycle after its last byte is taken. An
// immediate-only form with no immediate bytes completes on its start byte.
// Bytes without a start while idle are consumed and ignored.
//
// A single output register parts the two sides; while it holds a result that
// the receiver has not taken, byte_stream is held off, otherwise a byte is
// taken in every cycle, including the one in which the result is drained.
// Reset returns the parser to idle with all context cleared and no result.
module x86_modrm_sib_operand_parser_core (
	input logic              clk,
	input logic              arst_n,
	x86op_in_if.sink         byte_stream,
	x86op_out_if.source      operands
);
	import x86op_pkg::*;

	parse_state_t cur;
	parse_state_t nxt;
	out_item_t    result;
	out_item_t    res_q;
	logic         emit;
	logic         accept;
	logic         res_valid_q;

	assign byte_stream.ready = !res_valid_q || operands.ready;
	assign accept = byte_stream.valid && byte_stream.ready;

	x86op_step u_step (
		.cur    (cur),
		.item   (byte_stream.data),
		.nxt    (nxt),
		.emit   (emit),
		.result (result)
	);

	x86op_core_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (accept),
		.nxt    (nxt),
		.cur    (cur)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept && emit) begin
			res_valid_q <= 1'b1;
		end else if (operands.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit)
			res_q <= result;
	end

	assign operands.valid = res_valid_q;
	assign operands.data  = res_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !operands.ready |-> !byte_stream.ready)
		else $error("pending result could be overwritten");

	a_emit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		accept && emit |=> operands.valid)
		else $error("completed instruction gave no result");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		operands.valid && operands.data.bytes_used == 4'd0 |->
			operands.data.disp_size == 3'd0 && operands.data.immediate == 64'd0)
		else $error("empty instruction carries operand data");

endmodule
